>>> rtl/dsrl_pkg.sv
// ----------------------------------------------------------------------------
// dsrl_pkg
// shared constants, types and the star closure used by the line search block
// ----------------------------------------------------------------------------
package dsrl_pkg;

  localparam int MAX_TOKENS       = 32;
  localparam int LINE_NUMBER_BITS = 16;
  localparam int LINE_OUT_W       = 16;
  localparam int BYTE_W           = 8;

  localparam int TOK_IDX_W    = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int COUNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int ACT_W        = MAX_TOKENS + 1;
  localparam int CLOSE_LEVELS = $clog2(ACT_W);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_BYTE   = 2'd2;
  localparam logic [1:0] OP_EOL    = 2'd3;

  localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [BYTE_W-1:0] ANY_BYTE  = 8'h2E;

  typedef logic [ACT_W-1:0]      act_t;
  typedef logic [MAX_TOKENS-1:0] tok_t;

  // one word as it leaves the input register
  typedef struct packed {
    logic              fire;
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] data_byte;
  } cmd_t;

  // current pattern as seen by the nfa
  typedef struct packed {
    logic [MAX_TOKENS-1:0][BYTE_W-1:0] chars;
    tok_t                              starred;
    tok_t                              in_use;
    logic [COUNT_W-1:0]                count;
    logic                              overflow;
  } pattern_t;

  // end of line report
  typedef struct packed {
    logic                        matched;
    logic [LINE_NUMBER_BITS-1:0] line_number;
  } result_t;

  // position j+1 becomes active when position j is active and token j is
  // starred; runs of starred tokens resolved as a parallel prefix
  function automatic act_t close_set(act_t s, tok_t starred);
    act_t g;
    act_t p;
    act_t gn;
    act_t pn;
    g = s;
    p = {starred, 1'b0};
    for (int lvl = 0; lvl < CLOSE_LEVELS; lvl++) begin
      gn = g;
      pn = p;
      for (int j = 0; j < ACT_W; j++) begin
        if (j >= (1 << lvl)) begin
          gn[j] = g[j] | (p[j] & g[j - (1 << lvl)]);
          pn[j] = p[j] & p[j - (1 << lvl)];
        end
      end
      g = gn;
      p = pn;
    end
    return g;
  endfunction

endpackage

>>> rtl/dot_star_regex_line_search.sv
// ----------------------------------------------------------------------------
// dot_star_regex_line_search
// unanchored per-line search for literals, '.' and starred tokens, bit-parallel
// an end-of-line word is held in the input register, its report in the result register
// throughput: one word per cycle with a combinational nfa step; an end-of-line
//   word behind a stalled report waits in the input register and stalls the input
// reset: synchronous rst_n empties the pattern, line state and line count;
//   the design accepts words in the first cycle after reset
// ----------------------------------------------------------------------------
module dot_star_regex_line_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic [dsrl_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_matched,
  output logic [dsrl_pkg::LINE_OUT_W-1:0] out_line_number,
  output logic                            out_pattern_overflow
);
  import dsrl_pkg::*;

  // input register stage
  logic              s1_valid_r;
  logic [1:0]        s1_op_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_fire;
  logic              s1_open;
  logic              in_fire;

  // result register stage
  logic                  out_valid_r;
  logic                  out_matched_r;
  logic [LINE_OUT_W-1:0] out_line_r;
  logic                  out_ovf_r;
  logic                  out_free;
  logic                  eol_fire;

  cmd_t     cmd;
  pattern_t pat;
  result_t  res;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  // only end-of-line words wait on the result slot, the rest always retire
  assign s1_fire  = s1_valid_r && ((s1_op_r != OP_EOL) || out_free);
  assign eol_fire = s1_fire && (s1_op_r == OP_EOL);
  assign s1_open  = !s1_valid_r || s1_fire;
  assign in_stall = !s1_open;
  assign in_fire  = in_valid && s1_open;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_open) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_opcode;
      s1_data_r <= in_data_byte;
    end
  end

  assign cmd.fire      = s1_fire;
  assign cmd.opcode    = s1_op_r;
  assign cmd.data_byte = s1_data_r;

  // token slots and star flags
  dsrl_pattern u_pattern (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .pat   (pat)
  );

  // active positions, match flag and line counter
  dsrl_nfa u_nfa (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .pat   (pat),
    .res   (res)
  );

  // result register, loaded only at end of line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eol_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eol_fire) begin
      out_matched_r <= res.matched;
      out_line_r    <= LINE_OUT_W'(res.line_number);
      out_ovf_r     <= pat.overflow;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_line_number      = out_line_r;
  assign out_pattern_overflow = out_ovf_r;

  // token count stays within the slot capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pat.count <= COUNT_W'(MAX_TOKENS))
    else $error("token count beyond capacity");

  // a clear leaves an empty pattern without overflow
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_op_r == OP_CLEAR)) |=> (pat.count == '0) && !pat.overflow)
    else $error("clear did not empty the pattern");

  // an end-of-line word never retires while the result slot is blocked
  a_eol_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_op_r == OP_EOL) && out_valid_r && out_stall)
      |=> s1_valid_r && (s1_op_r == OP_EOL) && out_valid_r)
    else $error("end of line lost behind a stalled result");

  // a line result appears only after an end-of-line word retires
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(eol_fire))
    else $error("result without end of line");

endmodule

>>> rtl/dsrl_pattern.sv
// ----------------------------------------------------------------------------
// dsrl_pattern
// token store: appends bytes, folds a star into an unstarred previous token
// ----------------------------------------------------------------------------
module dsrl_pattern (
  input  logic              clk,
  input  logic              rst_n,
  input  dsrl_pkg::cmd_t    cmd,
  output dsrl_pkg::pattern_t pat
);
  import dsrl_pkg::*;

  logic [MAX_TOKENS-1:0][BYTE_W-1:0] chars_r;
  tok_t                              starred_r;
  tok_t                              starred_nxt;
  logic [COUNT_W-1:0]                count_r;
  logic [COUNT_W-1:0]                count_nxt;
  logic                              overflow_r;
  logic                              overflow_nxt;
  logic                              write_char;
  logic [TOK_IDX_W-1:0]              last_idx;
  logic [TOK_IDX_W-1:0]              new_idx;
  logic                              star_fold;
  logic                              has_room;
  tok_t                              in_use;

  assign last_idx  = TOK_IDX_W'(count_r - COUNT_W'(1));
  assign new_idx   = TOK_IDX_W'(count_r);
  assign has_room  = count_r < COUNT_W'(MAX_TOKENS);
  assign star_fold = (cmd.data_byte == STAR_BYTE) && (count_r != '0) &&
                     !starred_r[last_idx];

  always_comb begin
    starred_nxt  = starred_r;
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    write_char   = 1'b0;
    if (cmd.fire) begin
      unique case (cmd.opcode)
        OP_CLEAR: begin
          starred_nxt  = '0;
          count_nxt    = '0;
          overflow_nxt = 1'b0;
        end
        OP_APPEND: begin
          priority if (star_fold) begin
            starred_nxt[last_idx] = 1'b1;
          end else if (has_room) begin
            write_char           = 1'b1;
            starred_nxt[new_idx] = 1'b0;
            count_nxt            = count_r + COUNT_W'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
        end
        OP_BYTE, OP_EOL: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      starred_r  <= '0;
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      starred_r  <= starred_nxt;
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // slots above the count are never read, so no reset
  always_ff @(posedge clk) begin
    if (write_char) begin
      chars_r[new_idx] <= cmd.data_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      in_use[i] = COUNT_W'(i) < count_r;
    end
  end

  assign pat.in_use   = in_use;
  assign pat.chars    = chars_r;
  assign pat.starred  = starred_r;
  assign pat.count    = count_r;
  assign pat.overflow = overflow_r;

endmodule

>>> rtl/dsrl_nfa.sv
// ----------------------------------------------------------------------------
// dsrl_nfa
// active position vector, per-line match flag and line counter
// ----------------------------------------------------------------------------
module dsrl_nfa (
  input  logic               clk,
  input  logic               rst_n,
  input  dsrl_pkg::cmd_t     cmd,
  input  dsrl_pkg::pattern_t pat,
  output dsrl_pkg::result_t  res
);
  import dsrl_pkg::*;

  act_t                        active_r;
  act_t                        active_nxt;
  logic                        match_r;
  logic                        match_nxt;
  logic [LINE_NUMBER_BITS-1:0] lines_r;
  logic [LINE_NUMBER_BITS-1:0] lines_nxt;
  logic [LINE_NUMBER_BITS-1:0] lines_inc;
  act_t                        cur;
  act_t                        stepped;
  act_t                        nxt;
  logic                        cur_accept;
  logic                        nxt_accept;
  logic                        hit;

  // new attempt injected at position zero, then closed over stars
  assign cur        = close_set(active_r | ACT_W'(1), pat.starred);
  assign cur_accept = cur[pat.count];

  always_comb begin
    stepped = '0;
    hit     = 1'b0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      hit = pat.in_use[i] && cur[i] &&
            ((pat.chars[i] == ANY_BYTE) || (pat.chars[i] == cmd.data_byte));
      if (pat.starred[i]) begin
        stepped[i] = stepped[i] | hit;
      end else begin
        stepped[i+1] = stepped[i+1] | hit;
      end
    end
  end

  assign nxt        = close_set(stepped, pat.starred);
  assign nxt_accept = nxt[pat.count];
  assign lines_inc  = (lines_r != '1) ? lines_r + LINE_NUMBER_BITS'(1) : lines_r;

  always_comb begin
    active_nxt = active_r;
    match_nxt  = match_r;
    lines_nxt  = lines_r;
    if (cmd.fire) begin
      unique case (cmd.opcode)
        OP_CLEAR: begin
          active_nxt = '0;
          match_nxt  = 1'b0;
          lines_nxt  = '0;
        end
        OP_APPEND: begin
        end
        OP_BYTE: begin
          active_nxt = nxt;
          match_nxt  = match_r | cur_accept | nxt_accept;
        end
        OP_EOL: begin
          active_nxt = '0;
          match_nxt  = 1'b0;
          lines_nxt  = lines_inc;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      match_r  <= 1'b0;
      lines_r  <= '0;
    end else begin
      active_r <= active_nxt;
      match_r  <= match_nxt;
      lines_r  <= lines_nxt;
    end
  end

  assign res.matched     = match_r | cur_accept;
  assign res.line_number = lines_inc;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the line search block: a queue-fed driver streams
// pattern, line and end-of-line words, a bit-level search predictor tracks
// every accepted word and a monitor checks each line report in order
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsrl_pkg::*;

  localparam int unsigned        CYCLE_LIMIT = 3000000;
  localparam longint unsigned    LINE_CAP    = (64'd1 << LINE_NUMBER_BITS) - 1;
  localparam int                 RANDOM_WORDS = 500;

  // one word for the input channel plus the idle cycles that precede it
  typedef struct {
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] data;
    int unsigned       gap;
  } word_t;

  // one end-of-line report as the block should give it
  typedef struct {
    logic                  matched;
    logic [LINE_OUT_W-1:0] line_number;
    logic                  pattern_overflow;
  } line_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_opcode = OP_CLEAR;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_matched;
  logic [LINE_OUT_W-1:0] out_line_number;
  logic                  out_pattern_overflow;

  dot_star_regex_line_search dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_matched          (out_matched),
    .out_line_number      (out_line_number),
    .out_pattern_overflow (out_pattern_overflow)
  );

  always #5 clk = ~clk;

  // words waiting to be offered and reports waiting to come back
  word_t        word_q[$];
  line_report_t due_reports[$];

  // bookkeeping
  int unsigned cyc = 0;
  int unsigned words_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm = 1'b0;

  // search state as the block should hold it
  logic [BYTE_W-1:0] pat_char [MAX_TOKENS];
  tok_t              pat_star = '0;
  int                pat_len = 0;
  act_t              live_pos = '0;
  logic              hit_seen = 1'b0;
  longint unsigned   lines_seen = 0;
  logic              pat_dropped = 1'b0;

  // ---------------------------------------------------------------------------
  // search predictor
  // ---------------------------------------------------------------------------

  // a live position in front of a starred token also makes the next one live;
  // walking upward lets runs of starred tokens chain through
  function automatic act_t star_closure(act_t s);
    act_t r;
    r = s;
    for (int i = 0; i < pat_len; i++)
      if (r[i] && pat_star[i]) r[i+1] = 1'b1;
    return r;
  endfunction

  // apply one accepted word to the predicted state, queue a report on eol
  task automatic advance_search(input logic [1:0] op, input logic [BYTE_W-1:0] b);
    act_t         cur;
    act_t         nxt;
    line_report_t rep;
    case (op)
      OP_CLEAR: begin
        pat_star    = '0;
        pat_len     = 0;
        lines_seen  = 0;
        pat_dropped = 1'b0;
        live_pos    = '0;
        hit_seen    = 1'b0;
      end
      OP_APPEND: begin
        // a star only binds to an unstarred token; else a plain token, if room
        if (b == STAR_BYTE && pat_len > 0 && !pat_star[pat_len-1]) begin
          pat_star[pat_len-1] = 1'b1;
        end else if (pat_len < MAX_TOKENS) begin
          pat_char[pat_len] = b;
          pat_star[pat_len] = 1'b0;
          pat_len++;
        end else begin
          pat_dropped = 1'b1;
        end
      end
      OP_BYTE: begin
        // a fresh attempt starts at every byte, the empty match included
        cur = star_closure(live_pos | act_t'(1));
        if (cur[pat_len]) hit_seen = 1'b1;
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (cur[i] && (pat_char[i] == ANY_BYTE || pat_char[i] == b)) begin
            if (pat_star[i]) nxt[i] = 1'b1;
            else nxt[i+1] = 1'b1;
          end
        end
        nxt = star_closure(nxt);
        if (nxt[pat_len]) hit_seen = 1'b1;
        live_pos = nxt;
      end
      default: begin
        // end of line: one last attempt at the end of the text
        cur = star_closure(live_pos | act_t'(1));
        if (cur[pat_len]) hit_seen = 1'b1;
        if (lines_seen < LINE_CAP) lines_seen++;
        rep.matched          = hit_seen;
        rep.line_number      = lines_seen[LINE_OUT_W-1:0];
        rep.pattern_overflow = pat_dropped;
        due_reports = {due_reports, rep};
        live_pos = '0;
        hit_seen = 1'b0;
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // small alphabet so that matches are common, any byte now and then
  function automatic logic [BYTE_W-1:0] pick_text_byte(input logic with_star);
    case ($urandom_range(0, 9))
      0, 1:    return "a";
      2, 3:    return "b";
      4:       return "c";
      5:       return ANY_BYTE;
      6, 7:    return with_star ? STAR_BYTE : "a";
      8:       return BYTE_W'($urandom_range(0, 255));
      default: return "b";
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_plain_byte();
    case ($urandom_range(0, 4))
      0:       return "a";
      1:       return "b";
      2:       return ANY_BYTE;
      3:       return BYTE_W'($urandom_range(0, 255)) & 8'hFD;
      default: return "c";
    endcase
  endfunction

  task automatic add_word(input logic [1:0] op, input logic [BYTE_W-1:0] b);
    word_t w;
    w.opcode = op;
    w.data   = b;
    w.gap    = calm ? 0 : pick_gap();
    word_q = {word_q, w};
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued words, holds a stalled word steady
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    int unsigned idle_cnt;
    word_t       nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_cnt = 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_search(in_opcode, in_data_byte);
        words_sent <= words_sent + 1;
      end
      if (in_valid && in_stall) in_stall_cycles <= in_stall_cycles + 1;
      // free to move on once the current word is gone or none is up
      if (!in_valid || !in_stall) begin
        if (word_q.size() != 0 && idle_cnt >= word_q[0].gap) begin
          nxt = word_q.pop_front();
          in_opcode    <= nxt.opcode;
          in_data_byte <= nxt.data;
          in_valid     <= 1'b1;
          idle_cnt = 0;
        end else begin
          in_valid <= 1'b0;
          if (word_q.size() != 0) idle_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long receiver hold-off, once, while the sender keeps offering
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_sent >= 60) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted report against the oldest one due
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    line_report_t want;
    int unsigned  stall_left;
    logic         stall_now;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          note_mismatch("unexpected report, line number", 64'd0,
                        64'(out_line_number));
        end else begin
          want = due_reports.pop_front();
          reports_checked <= reports_checked + 1;
          if (out_matched) hits_seen <= hits_seen + 1;
          if (out_matched !== want.matched)
            note_mismatch("matched", 64'(want.matched), 64'(out_matched));
          if (out_line_number !== want.line_number)
            note_mismatch("line_number", 64'(want.line_number),
                          64'(out_line_number));
          if (out_pattern_overflow !== want.pattern_overflow)
            note_mismatch("pattern_overflow", 64'(want.pattern_overflow),
                          64'(out_pattern_overflow));
        end
      end
      // stall runs of random length, with windows of no stalling at all
      if (stall_left == 0 && (cyc / 512) % 4 != 0)
        stall_left = $urandom_range(0, 1) ? pick_gap() : 0;
      stall_now = 1'b0;
      if (stall_left != 0) begin
        stall_left--;
        stall_now = 1'b1;
      end
      out_stall <= stall_now || (hold_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // run limit
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still due", cyc, due_reports.size());
      $display("dot_star_regex_line_search verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned first_random;
    int unsigned seq;
    int unsigned n_tok;
    int unsigned n_lines;
    int unsigned n_bytes;

    // directed words
    add_word(OP_CLEAR, 8'hFF);
    add_word(OP_EOL, 8'hA5);            // empty pattern matches an empty line
    add_word(OP_APPEND, STAR_BYTE);     // leading star is a literal token
    add_word(OP_APPEND, STAR_BYTE);     // ...which this one stars
    add_word(OP_APPEND, STAR_BYTE);     // star after a starred token: literal
    add_word(OP_APPEND, "a");
    add_word(OP_APPEND, STAR_BYTE);
    add_word(OP_APPEND, ANY_BYTE);
    add_word(OP_BYTE, 8'h00);
    add_word(OP_BYTE, STAR_BYTE);
    add_word(OP_BYTE, 8'hFF);
    add_word(OP_EOL, 8'h00);
    add_word(OP_BYTE, 8'h00);
    add_word(OP_EOL, 8'hFF);
    add_word(OP_CLEAR, 8'h00);
    add_word(OP_APPEND, 8'h00);
    add_word(OP_APPEND, 8'hFF);
    add_word(OP_BYTE, 8'h00);
    add_word(OP_APPEND, "q");           // pattern grows in the middle of a line
    add_word(OP_BYTE, 8'hFF);
    add_word(OP_BYTE, "q");
    add_word(OP_EOL, 8'h5A);
    add_word(OP_EOL, 8'h00);            // empty line, pattern not empty
    add_word(OP_BYTE, 8'h55);
    add_word(OP_EOL, 8'hAA);

    // random part: well-formed pattern and line sequences, plus some noise
    first_random = word_q.size();
    seq = 0;
    while (word_q.size() < first_random + RANDOM_WORDS) begin
      calm = ($urandom_range(0, 3) == 0);
      if (seq == 0) begin
        // fill every slot, star the last token, then drop one byte
        add_word(OP_CLEAR, BYTE_W'($urandom_range(0, 255)));
        for (int k = 0; k < MAX_TOKENS; k++) add_word(OP_APPEND, pick_plain_byte());
        add_word(OP_APPEND, STAR_BYTE);
        add_word(OP_APPEND, "z");
      end else if ($urandom_range(0, 9) == 0) begin
        // noise: anything at all, broken sequences included
        repeat ($urandom_range(1, 6))
          add_word(2'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 9) < 3) add_word(OP_CLEAR, BYTE_W'($urandom_range(0, 255)));
        n_tok = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 5);
        repeat (n_tok) add_word(OP_APPEND, pick_text_byte(1'b1));
        n_lines = $urandom_range(1, 4);
        repeat (n_lines) begin
          n_bytes = $urandom_range(0, 10);
          repeat (n_bytes) begin
            if ($urandom_range(0, 19) == 0) add_word(OP_APPEND, pick_text_byte(1'b1));
            add_word(OP_BYTE, pick_text_byte(1'b1));
          end
          add_word(OP_EOL, BYTE_W'($urandom_range(0, 255)));
        end
      end
      seq++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (word_q.size() != 0 || in_valid) @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    // catch any report the block adds beyond what is due
    repeat (10) @(posedge clk);

    $display("sent %0d words over %0d random sequences; %0d line reports checked, %0d matched",
             words_sent, seq, reports_checked, hits_seen);
    $display("input held off %0d cycles behind stalled line reports",
             in_stall_cycles);
    if (mismatches == 0) begin
      $display("dot_star_regex_line_search verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("dot_star_regex_line_search verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dsrl_pkg.sv
rtl/dsrl_pattern.sv
rtl/dsrl_nfa.sv
rtl/dot_star_regex_line_search.sv
verif/tb_top.sv
